// ===== rtl/rstc_pkg.sv =====
// Shared constants, types and helper functions of the ray segment transition counter.
package rstc_pkg;

  localparam int REGIONS    = 256;
  localparam int COUNT_BITS = 32;
  localparam int RIDX_W     = (REGIONS > 1) ? $clog2(REGIONS) : 1;
  localparam int ICPT_AW    = 2 * RIDX_W;
  localparam int RDEPTH     = 1 << RIDX_W;
  localparam int ICPT_DEPTH = 1 << ICPT_AW;
  localparam int OUTQ_DEPTH = 4;
  localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
  localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

  localparam logic [7:0] ENGINE_AIR    = 8'd5;
  localparam logic [7:0] FROM_REGION   = 8'd0;
  localparam logic [7:0] FROM_EXTERIOR = 8'd1;

  localparam logic [1:0] OP_SEG   = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [1:0] Q_LEAVE = 2'd0;
  localparam logic [1:0] Q_ICPT  = 2'd1;
  localparam logic [1:0] Q_EXIT  = 2'd2;
  localparam logic [1:0] Q_MISS  = 2'd3;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [RIDX_W-1:0]     ridx_t;
  typedef logic [ICPT_AW-1:0]    icpt_addr_t;
  typedef logic [QPTR_W-1:0]     qptr_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;

  typedef struct packed {
    logic       lv_wr;
    logic       ic_wr;
    logic       ex_wr;
    logic       res;
    logic       rd;
    logic       rd_zero;
    logic       missed;
    logic [1:0] kind;
    ridx_t      lv_addr;
    ridx_t      ex_addr;
    icpt_addr_t ic_addr;
    cnt_t       miss_val;
  } cmd_t;

  typedef struct packed {
    logic       en;
    icpt_addr_t addr;
  } clr_t;

  typedef struct packed {
    logic        ray_missed;
    logic [31:0] count_value;
  } res_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : cnt_t'(v + 1'b1);
  endfunction

  function automatic logic [31:0] sat_out(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

endpackage

// ===== rtl/rstc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface rstc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       is_region;
  logic [7:0] region_index;
  logic [7:0] air_code;
  logic [1:0] query_kind;
  logic [7:0] query_row;
  logic [7:0] query_col;

  modport source (
    output valid, operation, is_region, region_index, air_code,
           query_kind, query_row, query_col,
    input  ready
  );
  modport sink (
    input  valid, operation, is_region, region_index, air_code,
           query_kind, query_row, query_col,
    output ready
  );
endinterface

interface rstc_out_if;
  logic        valid;
  logic        ready;
  logic        ray_missed;
  logic [31:0] count_value;

  modport source (output valid, ray_missed, count_value, input ready);
  modport sink (input valid, ray_missed, count_value, output ready);
endinterface

// ===== rtl/rstc_ctrl.sv =====
// Per-ray state machine, counter command issue and memory clearing sequencer.
module rstc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  rstc_in_if.sink            in_item,
  input  rstc_pkg::qcnt_t    q_cnt,
  input  logic               b_res,
  output rstc_pkg::cmd_t     cmd_r,
  output rstc_pkg::clr_t     clr
);

  logic [7:0]           came_from_r, came_from_nxt;
  logic [7:0]           last_region_r, last_region_nxt;
  logic                 prev_valid_r, prev_valid_nxt;
  logic                 had_seg_r, had_seg_nxt;
  rstc_pkg::cnt_t       miss_r, miss_nxt;
  logic                 pend_r, pend_nxt;
  logic [7:0]           pend_prev_r, pend_prev_nxt;
  logic [7:0]           pend_reg_r, pend_reg_nxt;
  rstc_pkg::cmd_t       cmd_nxt;
  logic                 clr_busy_r;
  rstc_pkg::icpt_addr_t clr_addr_r;
  rstc_pkg::qcnt_t      occ;
  logic                 accept;
  logic                 reg_ok, prev_ok, cur_ok, row_ok, col_ok;

  assign occ = rstc_pkg::qcnt_t'(q_cnt + rstc_pkg::qcnt_t'(cmd_r.res)
                                 + rstc_pkg::qcnt_t'(b_res));
  assign in_item.ready = !clr_busy_r && !pend_r
                         && (occ < rstc_pkg::qcnt_t'(rstc_pkg::OUTQ_DEPTH));
  assign accept = in_item.valid && in_item.ready;

  assign clr.en   = clr_busy_r;
  assign clr.addr = clr_addr_r;

  assign reg_ok  = 32'(in_item.region_index) < 32'(rstc_pkg::REGIONS);
  assign prev_ok = 32'(last_region_r) < 32'(rstc_pkg::REGIONS);
  assign cur_ok  = prev_ok;
  assign row_ok  = 32'(in_item.query_row) < 32'(rstc_pkg::REGIONS);
  assign col_ok  = 32'(in_item.query_col) < 32'(rstc_pkg::REGIONS);

  always_comb begin
    came_from_nxt   = came_from_r;
    last_region_nxt = last_region_r;
    prev_valid_nxt  = prev_valid_r;
    had_seg_nxt     = had_seg_r;
    miss_nxt        = miss_r;
    pend_nxt        = 1'b0;
    pend_prev_nxt   = pend_prev_r;
    pend_reg_nxt    = pend_reg_r;
    cmd_nxt         = '0;

    if (pend_r) begin
      cmd_nxt.lv_wr   = 32'(pend_reg_r) < 32'(rstc_pkg::REGIONS);
      cmd_nxt.lv_addr = rstc_pkg::ridx_t'(pend_reg_r);
      cmd_nxt.ic_wr   = (32'(pend_reg_r) < 32'(rstc_pkg::REGIONS))
                        && (32'(pend_prev_r) < 32'(rstc_pkg::REGIONS));
      cmd_nxt.ic_addr = {rstc_pkg::ridx_t'(pend_reg_r), rstc_pkg::ridx_t'(pend_prev_r)};
    end

    if (accept) begin
      case (in_item.operation)
        rstc_pkg::OP_SEG: begin
          had_seg_nxt = 1'b1;
          if (in_item.is_region) begin
            if (came_from_r == rstc_pkg::ENGINE_AIR && prev_valid_r) begin
              cmd_nxt.lv_wr   = prev_ok;
              cmd_nxt.lv_addr = rstc_pkg::ridx_t'(last_region_r);
              cmd_nxt.ic_wr   = prev_ok && reg_ok;
              cmd_nxt.ic_addr = {rstc_pkg::ridx_t'(last_region_r),
                                 rstc_pkg::ridx_t'(in_item.region_index)};
              pend_nxt        = 1'b1;
              pend_prev_nxt   = last_region_r;
              pend_reg_nxt    = in_item.region_index;
            end
            last_region_nxt = in_item.region_index;
            prev_valid_nxt  = 1'b1;
            came_from_nxt   = rstc_pkg::FROM_REGION;
          end else if (came_from_r != rstc_pkg::ENGINE_AIR) begin
            if (came_from_r == rstc_pkg::FROM_REGION
                && in_item.air_code == rstc_pkg::ENGINE_AIR) begin
              cmd_nxt.ex_wr   = cur_ok;
              cmd_nxt.ex_addr = rstc_pkg::ridx_t'(last_region_r);
            end
            came_from_nxt = in_item.air_code;
          end
        end
        rstc_pkg::OP_END: begin
          cmd_nxt.res    = 1'b1;
          cmd_nxt.missed = !prev_valid_r;
          if (!had_seg_r) begin
            miss_nxt = rstc_pkg::sat_inc(miss_r);
          end
          came_from_nxt   = rstc_pkg::FROM_EXTERIOR;
          last_region_nxt = 8'd0;
          prev_valid_nxt  = 1'b0;
          had_seg_nxt     = 1'b0;
        end
        rstc_pkg::OP_READ: begin
          cmd_nxt.res      = 1'b1;
          cmd_nxt.rd       = 1'b1;
          cmd_nxt.kind     = in_item.query_kind;
          cmd_nxt.rd_zero  = (in_item.query_kind != rstc_pkg::Q_MISS)
                             && (!row_ok || (in_item.query_kind == rstc_pkg::Q_ICPT
                                             && !col_ok));
          cmd_nxt.lv_addr  = rstc_pkg::ridx_t'(in_item.query_row);
          cmd_nxt.ex_addr  = rstc_pkg::ridx_t'(in_item.query_row);
          cmd_nxt.ic_addr  = {rstc_pkg::ridx_t'(in_item.query_row),
                              rstc_pkg::ridx_t'(in_item.query_col)};
          cmd_nxt.miss_val = miss_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      came_from_r   <= rstc_pkg::FROM_EXTERIOR;
      last_region_r <= 8'd0;
      prev_valid_r  <= 1'b0;
      had_seg_r     <= 1'b0;
      miss_r        <= '0;
      pend_r        <= 1'b0;
      pend_prev_r   <= 8'd0;
      pend_reg_r    <= 8'd0;
      cmd_r         <= '0;
      clr_busy_r    <= 1'b1;
      clr_addr_r    <= '0;
    end else begin
      came_from_r   <= came_from_nxt;
      last_region_r <= last_region_nxt;
      prev_valid_r  <= prev_valid_nxt;
      had_seg_r     <= had_seg_nxt;
      miss_r        <= miss_nxt;
      pend_r        <= pend_nxt;
      pend_prev_r   <= pend_prev_nxt;
      pend_reg_r    <= pend_reg_nxt;
      cmd_r         <= cmd_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= rstc_pkg::icpt_addr_t'(clr_addr_r + 1'b1);
        if (clr_addr_r == '1) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/rstc_cnt.sv =====
// Counter memories with a read-modify-write pipeline, write forwarding and read-out.
module rstc_cnt (
  input  logic            clk,
  input  logic            rst_n,
  input  rstc_pkg::cmd_t  cmd,
  input  rstc_pkg::clr_t  clr,
  output logic            b_res,
  output logic            res_vld,
  output rstc_pkg::res_t  res
);

  rstc_pkg::cnt_t       lv_mem [rstc_pkg::RDEPTH];
  rstc_pkg::cnt_t       ex_mem [rstc_pkg::RDEPTH];
  rstc_pkg::cnt_t       ic_mem [rstc_pkg::ICPT_DEPTH];

  rstc_pkg::cmd_t       cmdb_r;
  rstc_pkg::cnt_t       lv_rd_r, ex_rd_r, ic_rd_r;

  logic                 wl_lv_v_r, wl_ex_v_r, wl_ic_v_r;
  rstc_pkg::ridx_t      wl_lv_addr_r, wl_ex_addr_r;
  rstc_pkg::icpt_addr_t wl_ic_addr_r;
  rstc_pkg::cnt_t       wl_lv_dat_r, wl_ex_dat_r, wl_ic_dat_r;

  rstc_pkg::cnt_t       lv_cur, ex_cur, ic_cur;
  rstc_pkg::cnt_t       lv_new, ex_new, ic_new;
  rstc_pkg::cnt_t       sel;
  rstc_pkg::ridx_t      clr_small;

  assign clr_small = rstc_pkg::ridx_t'(clr.addr);

  // forward the write of the previous cycle
  assign lv_cur = (wl_lv_v_r && wl_lv_addr_r == cmdb_r.lv_addr) ? wl_lv_dat_r : lv_rd_r;
  assign ex_cur = (wl_ex_v_r && wl_ex_addr_r == cmdb_r.ex_addr) ? wl_ex_dat_r : ex_rd_r;
  assign ic_cur = (wl_ic_v_r && wl_ic_addr_r == cmdb_r.ic_addr) ? wl_ic_dat_r : ic_rd_r;

  assign lv_new = rstc_pkg::sat_inc(lv_cur);
  assign ex_new = rstc_pkg::sat_inc(ex_cur);
  assign ic_new = rstc_pkg::sat_inc(ic_cur);

  always_comb begin
    case (cmdb_r.kind)
      rstc_pkg::Q_LEAVE: sel = lv_cur;
      rstc_pkg::Q_ICPT:  sel = ic_cur;
      rstc_pkg::Q_EXIT:  sel = ex_cur;
      rstc_pkg::Q_MISS:  sel = cmdb_r.miss_val;
      default:           sel = '0;
    endcase
  end

  assign b_res           = cmdb_r.res;
  assign res_vld         = cmdb_r.res;
  assign res.ray_missed  = cmdb_r.missed;
  assign res.count_value = (cmdb_r.rd && !cmdb_r.rd_zero) ? rstc_pkg::sat_out(sel) : 32'd0;

  always_ff @(posedge clk) begin
    lv_rd_r <= lv_mem[cmd.lv_addr];
    if (clr.en) begin
      lv_mem[clr_small] <= '0;
    end else if (cmdb_r.lv_wr) begin
      lv_mem[cmdb_r.lv_addr] <= lv_new;
    end
  end

  always_ff @(posedge clk) begin
    ex_rd_r <= ex_mem[cmd.ex_addr];
    if (clr.en) begin
      ex_mem[clr_small] <= '0;
    end else if (cmdb_r.ex_wr) begin
      ex_mem[cmdb_r.ex_addr] <= ex_new;
    end
  end

  always_ff @(posedge clk) begin
    ic_rd_r <= ic_mem[cmd.ic_addr];
    if (clr.en) begin
      ic_mem[clr.addr] <= '0;
    end else if (cmdb_r.ic_wr) begin
      ic_mem[cmdb_r.ic_addr] <= ic_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmdb_r    <= '0;
      wl_lv_v_r <= 1'b0;
      wl_ex_v_r <= 1'b0;
      wl_ic_v_r <= 1'b0;
    end else begin
      cmdb_r    <= cmd;
      wl_lv_v_r <= cmdb_r.lv_wr;
      wl_ex_v_r <= cmdb_r.ex_wr;
      wl_ic_v_r <= cmdb_r.ic_wr;
    end
  end

  always_ff @(posedge clk) begin
    wl_lv_addr_r <= cmdb_r.lv_addr;
    wl_ex_addr_r <= cmdb_r.ex_addr;
    wl_ic_addr_r <= cmdb_r.ic_addr;
    wl_lv_dat_r  <= lv_new;
    wl_ex_dat_r  <= ex_new;
    wl_ic_dat_r  <= ic_new;
  end

endmodule

// ===== rtl/rstc_outq.sv =====
// Result queue between the counter pipeline and the output channel.
module rstc_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rstc_pkg::res_t  push_res,
  rstc_out_if.source      out_item,
  output rstc_pkg::qcnt_t q_cnt
);

  rstc_pkg::res_t  q_r [rstc_pkg::OUTQ_DEPTH];
  rstc_pkg::qptr_t wr_ptr_r, rd_ptr_r;
  rstc_pkg::qcnt_t cnt_r;
  logic            pop;

  assign pop                  = out_item.valid && out_item.ready;
  assign out_item.valid       = (cnt_r != '0);
  assign out_item.ray_missed  = q_r[rd_ptr_r].ray_missed;
  assign out_item.count_value = q_r[rd_ptr_r].count_value;
  assign q_cnt                = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= rstc_pkg::qptr_t'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= rstc_pkg::qptr_t'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= rstc_pkg::qcnt_t'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= rstc_pkg::qcnt_t'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/ray_segment_transition_counter.sv =====
// Top level of the ray segment transition counter.
// A result reaches out_item through cmd_r, the cmdb_r stage and the result queue.
// Throughput: one transaction per cycle while ready is high; a region entered from engine air
//   lowers ready, as its four updates share one port each of the leave and intercept RAMs.
// Reset: per-ray state and miss count clear at once; a clearing pass then zeroes the
//   counter RAMs over all 2^(2*RIDX_W) addresses (65536 at 256 regions) with ready low.
module ray_segment_transition_counter (
  input  logic       clk,
  input  logic       rst_n,
  rstc_in_if.sink    in_item,
  rstc_out_if.source out_item
);

  rstc_pkg::cmd_t  cmd;
  rstc_pkg::clr_t  clr;
  rstc_pkg::res_t  res;
  rstc_pkg::qcnt_t q_cnt;
  logic            b_res;
  logic            res_vld;

  rstc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .q_cnt   (q_cnt),
    .b_res   (b_res),
    .cmd_r   (cmd),
    .clr     (clr)
  );

  rstc_cnt u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .clr     (clr),
    .b_res   (b_res),
    .res_vld (res_vld),
    .res     (res)
  );

  rstc_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_vld),
    .push_res (res),
    .out_item (out_item),
    .q_cnt    (q_cnt)
  );

endmodule
